### design/crc8cfr_pkg.sv
// Shared types, frame constants and the CRC-8 byte update for the command receiver.
`timescale 1ns / 1ps

package crc8cfr_pkg;

    localparam logic [7:0] HDR_FIRST  = 8'hAA;
    localparam logic [7:0] HDR_SECOND = 8'h55;
    localparam logic [7:0] WANT_VER   = 8'h01;
    localparam logic [7:0] WANT_TYPE  = 8'h02;
    localparam logic [7:0] WANT_LEN   = 8'h02;
    localparam logic [7:0] CRC_POLY   = 8'h07;
    localparam logic [7:0] CRC_INIT   = 8'h00;

    localparam logic [1:0] REG_START = 2'd0;
    localparam logic [1:0] REG_STOP  = 2'd1;
    localparam logic [1:0] REG_DUTY  = 2'd2;

    localparam logic [7:0] START_RESET = 8'd1;
    localparam logic [7:0] STOP_RESET  = 8'd2;
    localparam logic [7:0] DUTY_RESET  = 8'd3;

    typedef logic [1:0] kind_t;

    localparam kind_t KIND_START = 2'd0;
    localparam kind_t KIND_STOP  = 2'd1;
    localparam kind_t KIND_DUTY  = 2'd2;

    typedef struct packed {
        logic [7:0] start_code;
        logic [7:0] stop_code;
        logic [7:0] duty_code;
    } cmd_codes_t;

    typedef struct packed {
        logic       valid;
        kind_t      kind;
        logic [7:0] value;
    } frame_result_t;

    // MSB-first CRC-8, no reflection, no final XOR
    function automatic logic [7:0] crc8_add_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] v;
        v = crc ^ b;
        for (int k = 0; k < 8; k++)
        begin
            if (v[7])
            begin
                v = {v[6:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                v = {v[6:0], 1'b0};
            end
        end
        return v;
    endfunction

endpackage

### design/crc8cfr_deframer.sv
// Frame tracker: header hunt, field checks, running CRC and command match.
`timescale 1ns / 1ps

module crc8cfr_deframer (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       accept,
    input  logic [7:0]                 data,
    input  crc8cfr_pkg::cmd_codes_t    codes,
    output crc8cfr_pkg::frame_result_t result
);
    import crc8cfr_pkg::*;

    localparam logic [2:0] POS_HDR1  = 3'd0;
    localparam logic [2:0] POS_HDR2  = 3'd1;
    localparam logic [2:0] POS_VER   = 3'd2;
    localparam logic [2:0] POS_TYPE  = 3'd3;
    localparam logic [2:0] POS_LEN   = 3'd4;
    localparam logic [2:0] POS_CMD   = 3'd5;
    localparam logic [2:0] POS_VALUE = 3'd6;
    localparam logic [2:0] POS_CRC   = 3'd7;

    logic [2:0] pos_reg, pos_next;
    logic [7:0] crc_reg, crc_next;
    logic       ok_reg, ok_next;
    logic [7:0] cmd_reg, cmd_next;
    logic [7:0] val_reg, val_next;

    frame_result_t res;

    always_comb
    begin
        pos_next  = pos_reg;
        crc_next  = crc_reg;
        ok_next   = ok_reg;
        cmd_next  = cmd_reg;
        val_next  = val_reg;
        res.valid = 1'b0;
        res.kind  = KIND_START;
        res.value = val_reg;

        case (pos_reg)
            POS_HDR1:
            begin
                if (data == HDR_FIRST)
                begin
                    pos_next = POS_HDR2;
                end
            end
            POS_HDR2:
            begin
                // a bad second byte is not retried as a first header byte
                if (data == HDR_SECOND)
                begin
                    pos_next = POS_VER;
                    crc_next = CRC_INIT;
                    ok_next  = 1'b1;
                end
                else
                begin
                    pos_next = POS_HDR1;
                end
            end
            POS_VER:
            begin
                if (data != WANT_VER)
                begin
                    ok_next = 1'b0;
                end
            end
            POS_TYPE:
            begin
                if (data != WANT_TYPE)
                begin
                    ok_next = 1'b0;
                end
            end
            POS_LEN:
            begin
                if (data != WANT_LEN)
                begin
                    ok_next = 1'b0;
                end
            end
            POS_CMD:
            begin
                cmd_next = data;
            end
            POS_VALUE:
            begin
                val_next = data;
            end
            default:
            begin
                pos_next = POS_HDR1;
                // earlier registers win when codes overlap
                if (ok_reg && data == crc_reg)
                begin
                    if (cmd_reg == codes.start_code)
                    begin
                        res.valid = 1'b1;
                        res.kind  = KIND_START;
                    end
                    else if (cmd_reg == codes.stop_code)
                    begin
                        res.valid = 1'b1;
                        res.kind  = KIND_STOP;
                    end
                    else if (cmd_reg == codes.duty_code)
                    begin
                        res.valid = 1'b1;
                        res.kind  = KIND_DUTY;
                    end
                end
            end
        endcase

        if (pos_reg inside {[POS_VER:POS_VALUE]})
        begin
            crc_next = crc8_add_byte(crc_reg, data);
            pos_next = pos_reg + 3'd1;
        end

        res.valid = res.valid & accept;
    end

    assign result = res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= POS_HDR1;
            crc_reg <= CRC_INIT;
            ok_reg  <= 1'b1;
            cmd_reg <= 8'd0;
            val_reg <= 8'd0;
        end
        else if (accept)
        begin
            pos_reg <= pos_next;
            crc_reg <= crc_next;
            ok_reg  <= ok_next;
            cmd_reg <= cmd_next;
            val_reg <= val_next;
        end
    end

    a_result_on_crc_byte: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> (pos_reg == POS_CRC && ok_reg && data == crc_reg))
        else $error("result raised outside a valid CRC byte");

    a_header_enters_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && pos_reg == POS_HDR2 && data == HDR_SECOND)
            |=> (pos_reg == POS_VER && crc_reg == CRC_INIT && ok_reg))
        else $error("header did not start a fresh frame");

    a_frame_ends_hunting: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && pos_reg == POS_CRC) |=> pos_reg == POS_HDR1)
        else $error("frame end did not return to hunting");

endmodule

### design/crc8_command_frame_receiver.sv
// Top level of the CRC-8 framed command receiver: code registers and result buffer.
`timescale 1ns / 1ps

// Takes one received byte per clock on the in channel while in_stall is low and returns,
// at most once per eight-byte frame (0xAA 0x55, version, type, length, command, value,
// CRC-8/0x07), the decoded command kind and value byte. Each byte is folded into the
// frame state in the cycle it is accepted, so the sustained rate is one byte per cycle
// while in_stall is low; a result is registered into the two-entry buffer (output
// register plus skid register), and in_stall rises only when both entries are full.
// Command codes are to be written through the cfg port only while the block is idle;
// the block does not enforce this. cfg_ready is always high; index 3 writes are ignored.
module crc8_command_frame_receiver (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         rx_data,
    output logic               out_valid,
    input  logic               out_stall,
    output crc8cfr_pkg::kind_t command_kind,
    output logic [7:0]         command_value,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [7:0]         cfg_data
);
    import crc8cfr_pkg::*;

    cmd_codes_t    codes_reg;
    frame_result_t frame_res;

    logic       accept;
    logic       pop;
    logic       push;

    logic       out_valid_reg;
    kind_t      out_kind_reg;
    logic [7:0] out_value_reg;
    logic       skid_valid_reg;
    kind_t      skid_kind_reg;
    logic [7:0] skid_value_reg;

    assign cfg_ready = 1'b1;
    assign in_stall  = skid_valid_reg;
    assign accept    = in_valid && !in_stall;
    assign pop       = out_valid_reg && !out_stall;
    assign push      = frame_res.valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            codes_reg.start_code <= START_RESET;
            codes_reg.stop_code  <= STOP_RESET;
            codes_reg.duty_code  <= DUTY_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_START: codes_reg.start_code <= cfg_data;
                REG_STOP:  codes_reg.stop_code  <= cfg_data;
                REG_DUTY:  codes_reg.duty_code  <= cfg_data;
                default:   ;
            endcase
        end
    end

    crc8cfr_deframer u_deframer (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .data   (rx_data),
        .codes  (codes_reg),
        .result (frame_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                if (skid_valid_reg)
                begin
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end
                else
                begin
                    out_valid_reg <= push;
                end
            end
            else if (!out_valid_reg)
            begin
                out_valid_reg <= push;
            end
            else if (push)
            begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    // payload: refill from skid, take a new request into the free slot
    always_ff @(posedge clk)
    begin
        if (pop && skid_valid_reg)
        begin
            out_kind_reg  <= skid_kind_reg;
            out_value_reg <= skid_value_reg;
        end
        else if (push && (pop || !out_valid_reg))
        begin
            out_kind_reg  <= frame_res.kind;
            out_value_reg <= frame_res.value;
        end
        else if (push)
        begin
            skid_kind_reg  <= frame_res.kind;
            skid_value_reg <= frame_res.value;
        end
    end

    assign out_valid     = out_valid_reg;
    assign command_kind  = out_kind_reg;
    assign command_value = out_value_reg;

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held while output register is empty");

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> !push)
        else $error("result produced while both buffer entries are full");

    a_blocked_push_to_skid: assert property (@(posedge clk) disable iff (!rst_n)
        (push && out_valid_reg && !pop) |=> (skid_valid_reg && out_valid_reg))
        else $error("result lost behind a stalled output");

    a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (command_kind == KIND_START || command_kind == KIND_STOP
                           || command_kind == KIND_DUTY))
        else $error("output holds an undefined command kind");

endmodule
